>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  `ASSERT_CLK(label, clk, rst, !(expr), msg)

`endif

>>> rtl/msbb_pkg.sv
// ----------------------------------------------------------------------------
// msbb_pkg
// Types and constants of the MSB-first bit buffer.
// ----------------------------------------------------------------------------
package msbb_pkg;

  localparam int BUF_BYTES  = 4096;
  localparam int CAP_BITS   = BUF_BYTES * 8;
  localparam int WORD_W     = 32;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = BUF_BYTES / (WORD_W / 8);
  localparam int WORD_AW    = $clog2(NUM_WORDS);
  localparam int BANK_DEPTH = NUM_WORDS / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int POS_W      = $clog2(CAP_BITS);
  localparam int COUNT_W    = 16;
  localparam int MAX_CODE_BITS = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CUT    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Write of one or two consecutive words; word is the first one.
  typedef struct packed {
    logic                en_first;
    logic                en_second;
    logic [WORD_AW-1:0]  word;
    logic [WORD_W-1:0]   data_first;
    logic [WORD_W-1:0]   data_second;
  } store_wr_t;

endpackage

>>> rtl/msb_first_bit_buffer_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_buffer_core
// MSB-first bit buffer: append codes, cut the tail, read single bits.
// ----------------------------------------------------------------------------
// The store is read on the accepting edge; in the execute state that follows,
// the store is written back while the result, status and done strobe are
// registered. No new transaction is accepted while busy, in the execute state.
// Reset clears the bit count and control state; the store itself is not
// cleared, and the results never depend on bits beyond the count.
module msb_first_bit_buffer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [31:0]                 code_bits,
  input  logic [5:0]                  code_length,
  input  logic [14:0]                 bit_index,
  input  logic [15:0]                 cut_count,
  output logic                        done,
  output logic                        bit_value,
  output logic [15:0]                 bit_length,
  output logic [1:0]                  status
);
  import msbb_pkg::*;

  state_t              state;
  state_t              state_next;
  logic                accept;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [1:0]          op_r;
  logic [WORD_W-1:0]   code_r;
  logic [5:0]          len_r;
  logic [COUNT_W-1:0]  cut_r;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_in;
  logic [WORD_W-1:0]   rd_first;
  logic [WORD_W-1:0]   rd_second;
  store_wr_t           wr;
  logic [OFF_W-1:0]    shl;
  logic [WORD_W-1:0]   mask32;
  logic [WORD_W-1:0]   data32;
  logic [2*WORD_W-1:0] mask64;
  logic [2*WORD_W-1:0] data64;
  logic [2*WORD_W-1:0] merged;
  logic [COUNT_W:0]    sum;
  logic                do_write;
  logic [1:0]          status_next;
  logic                value_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state == ST_EXEC);
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A read looks at the word holding the index; an append at the tail words.
  assign pos_in = (opcode == OP_READ) ? bit_index : count[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= opcode;
      code_r <= code_bits;
      len_r  <= code_length;
      cut_r  <= cut_count;
      pos_r  <= pos_in;
    end
  end

  msbb_store u_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_word   (pos_in[POS_W-1:OFF_W]),
    .wr        (wr),
    .rd_first  (rd_first),
    .rd_second (rd_second)
  );

  // Left-align the code in a word, then shift it to the bit offset of the tail.
  assign shl    = OFF_W'(6'd32 - len_r);
  assign mask32 = {WORD_W{1'b1}} << shl;
  assign data32 = code_r << shl;
  assign mask64 = {mask32, {WORD_W{1'b0}}} >> pos_r[OFF_W-1:0];
  assign data64 = {data32, {WORD_W{1'b0}}} >> pos_r[OFF_W-1:0];
  assign merged = ({rd_first, rd_second} & ~mask64) | data64;
  assign sum    = {1'b0, count} + (COUNT_W+1)'(len_r);

  always_comb begin
    count_next  = count;
    status_next = STAT_OK;
    value_next  = 1'b0;
    do_write    = 1'b0;
    case (op_r)
      OP_APPEND: begin
        if (len_r > 6'(MAX_CODE_BITS)) begin
          status_next = STAT_RANGE;
        end else if (sum > (COUNT_W+1)'(CAP_BITS)) begin
          status_next = STAT_OVERFLOW;
        end else begin
          count_next = sum[COUNT_W-1:0];
          do_write   = (len_r != 6'd0);
        end
      end
      OP_CUT: begin
        if (cut_r > count) begin
          count_next  = '0;
          status_next = STAT_RANGE;
        end else begin
          count_next = count - cut_r;
        end
      end
      OP_READ: begin
        if ({1'b0, pos_r} >= count) begin
          status_next = STAT_RANGE;
        end else begin
          // The first position of a word sits in its most significant bit.
          value_next = rd_first[~pos_r[OFF_W-1:0]];
        end
      end
      default: status_next = STAT_RANGE;
    endcase
  end

  always_comb begin
    wr.word        = pos_r[POS_W-1:OFF_W];
    wr.data_first  = merged[2*WORD_W-1:WORD_W];
    wr.data_second = merged[WORD_W-1:0];
    wr.en_first    = busy && do_write && (|mask64[2*WORD_W-1:WORD_W]);
    wr.en_second   = busy && do_write && (|mask64[WORD_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      bit_value  <= value_next;
      bit_length <= count_next;
      status     <= status_next;
    end
  end

endmodule

>>> rtl/msbb_store.sv
// ----------------------------------------------------------------------------
// msbb_store
// Bit store in two word banks, even and odd words, so that any two
// consecutive words are read or written together in one access.
// ----------------------------------------------------------------------------
module msbb_store (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [msbb_pkg::WORD_AW-1:0] rd_word,
  input  msbb_pkg::store_wr_t        wr,
  output logic [msbb_pkg::WORD_W-1:0]  rd_first,
  output logic [msbb_pkg::WORD_W-1:0]  rd_second
);
  import msbb_pkg::*;

  logic [WORD_W-1:0]  bank_even [BANK_DEPTH];
  logic [WORD_W-1:0]  bank_odd  [BANK_DEPTH];
  logic [WORD_W-1:0]  even_q;
  logic [WORD_W-1:0]  odd_q;
  logic               sel_q;
  logic [WORD_AW:0]   rd_succ;
  logic [WORD_AW:0]   wr_succ;
  logic [BANK_AW-1:0] rd_even_addr;
  logic [BANK_AW-1:0] wr_even_addr;
  logic [BANK_AW-1:0] wr_odd_addr;
  logic               wr_even_en;
  logic               wr_odd_en;
  logic [WORD_W-1:0]  wr_even_data;
  logic [WORD_W-1:0]  wr_odd_data;

  // The odd bank always holds word index >> 1 of the pair; the even bank
  // holds the successor's index >> 1 when the first word is odd.
  assign rd_succ      = {1'b0, rd_word} + (WORD_AW+1)'(1);
  assign rd_even_addr = rd_word[0] ? rd_succ[WORD_AW-1:1] : rd_word[WORD_AW-1:1];

  assign wr_succ      = {1'b0, wr.word} + (WORD_AW+1)'(1);
  assign wr_even_addr = wr.word[0] ? wr_succ[WORD_AW-1:1] : wr.word[WORD_AW-1:1];
  assign wr_odd_addr  = wr.word[WORD_AW-1:1];
  assign wr_even_en   = wr.word[0] ? wr.en_second : wr.en_first;
  assign wr_odd_en    = wr.word[0] ? wr.en_first : wr.en_second;
  assign wr_even_data = wr.word[0] ? wr.data_second : wr.data_first;
  assign wr_odd_data  = wr.word[0] ? wr.data_first : wr.data_second;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_q <= bank_even[rd_even_addr];
      odd_q  <= bank_odd[rd_word[WORD_AW-1:1]];
      sel_q  <= rd_word[0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_even_en) begin
      bank_even[wr_even_addr] <= wr_even_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_odd_en) begin
      bank_odd[wr_odd_addr] <= wr_odd_data;
    end
  end

  assign rd_first  = sel_q ? odd_q : even_q;
  assign rd_second = sel_q ? even_q : odd_q;

endmodule

>>> rtl/msbb_checker.sv
// ----------------------------------------------------------------------------
// msbb_checker
// Port-level checks of the bit buffer's command timing and results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msbb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        bit_value,
  input logic [15:0] bit_length,
  input logic [1:0]  status
);
  import msbb_pkg::*;

  `ASSERT_CLK(a_accept_busy, clk, rst, (start && !busy) |=> busy, "busy missing after accept")
  `ASSERT_CLK(a_accept_done, clk, rst, (start && !busy) |-> ##2 done, "result not on time")
  `ASSERT_NEVER(a_done_busy, clk, rst, done && busy, "result while busy")
  `ASSERT_NEVER(a_len_cap, clk, rst, done && (bit_length > 16'(CAP_BITS)), "length beyond capacity")
  `ASSERT_NEVER(a_value_ok, clk, rst, done && bit_value && (status != STAT_OK), "bit on failed transaction")

endmodule

bind msb_first_bit_buffer_core msbb_checker u_msbb_checker (.*);
